// File: hdl/wtv_pkg.sv
package wtv_pkg;

  // Default coordinate width and angle fraction bits
  localparam int COORD_WIDTH_DEF     = 32;
  localparam int ANGLE_FRAC_BITS_DEF = 13;

  // Register map indexes
  localparam int          NUM_REGS   = 8;
  localparam int          REG_IDX_W  = 3;
  localparam logic [2:0]  REG_HOST_POS_X   = 3'd0;
  localparam logic [2:0]  REG_HOST_POS_Y   = 3'd1;
  localparam logic [2:0]  REG_HOST_VEL_X   = 3'd2;
  localparam logic [2:0]  REG_HOST_VEL_Y   = 3'd3;
  localparam logic [2:0]  REG_HOST_ACC_X   = 3'd4;
  localparam logic [2:0]  REG_HOST_ACC_Y   = 3'd5;
  localparam logic [2:0]  REG_HOST_COURSE  = 3'd6;
  localparam logic [2:0]  REG_HOST_HEADING = 3'd7;

  // Sine/cosine rotator constants, 30 fraction bits (Q3.30 angles, Q2.30 gain)
  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_XW    = 33;
  localparam int CORDIC_ZW    = 34;
  localparam logic signed [CORDIC_ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CORDIC_ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CORDIC_XW-1:0] CORDIC_K    = 33'sd652032874;

  localparam logic [31:0] ATAN_Q30 [CORDIC_ITERS] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535,
    32'd32767,     32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127,       32'd63,
    32'd31,        32'd15,        32'd7,         32'd3,         32'd1
  };

  // Sine/cosine sequencer states
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOAD,
    CS_RUN,
    CS_DONE
  } cs_state_e;

endpackage

// File: hdl/wtv_in_if.sv
interface wtv_in_if #(
  parameter int W  = wtv_pkg::COORD_WIDTH_DEF,
  parameter int AW = wtv_pkg::ANGLE_FRAC_BITS_DEF + 3
);
  logic          valid;
  logic          ready;
  logic [W-1:0]  pt_pos_x;
  logic [W-1:0]  pt_pos_y;
  logic [W-1:0]  pt_vel_x;
  logic [W-1:0]  pt_vel_y;
  logic [W-1:0]  pt_acc_x;
  logic [W-1:0]  pt_acc_y;
  logic [AW-1:0] pt_course;
  logic [AW-1:0] pt_heading;
  logic [W-1:0]  pt_curvature;

  modport source (
    output valid, pt_pos_x, pt_pos_y, pt_vel_x, pt_vel_y, pt_acc_x, pt_acc_y,
           pt_course, pt_heading, pt_curvature,
    input  ready
  );
  modport sink (
    input  valid, pt_pos_x, pt_pos_y, pt_vel_x, pt_vel_y, pt_acc_x, pt_acc_y,
           pt_course, pt_heading, pt_curvature,
    output ready
  );
endinterface

// File: hdl/wtv_out_if.sv
interface wtv_out_if #(
  parameter int W  = wtv_pkg::COORD_WIDTH_DEF,
  parameter int AW = wtv_pkg::ANGLE_FRAC_BITS_DEF + 3
);
  logic          valid;
  logic          ready;
  logic [W-1:0]  rel_pos_x;
  logic [W-1:0]  rel_pos_y;
  logic [AW-1:0] rel_course;
  logic [AW-1:0] rel_heading;
  logic [W-1:0]  rel_vel_x;
  logic [W-1:0]  rel_vel_y;
  logic [W-2:0]  rel_speed;
  logic [W-1:0]  rel_acc_x;
  logic [W-1:0]  rel_acc_y;
  logic [W-2:0]  rel_acc_mag;
  logic [W-1:0]  rel_curvature;

  modport source (
    output valid, rel_pos_x, rel_pos_y, rel_course, rel_heading, rel_vel_x,
           rel_vel_y, rel_speed, rel_acc_x, rel_acc_y, rel_acc_mag, rel_curvature,
    input  ready
  );
  modport sink (
    input  valid, rel_pos_x, rel_pos_y, rel_course, rel_heading, rel_vel_x,
           rel_vel_y, rel_speed, rel_acc_x, rel_acc_y, rel_acc_mag, rel_curvature,
    output ready
  );
endinterface

// File: hdl/world_to_vehicle_frame_top.sv
// Channel   Dir  Handshake       Beat contents
// in_i      in   valid/ready     one object's world-frame state
// out_o     out  valid/ready     that object in the ego frame
// APB       in   psel/penable    ego pose registers, 4*i (8*i above 32 bits)
//
// One beat per cycle sustained unless out_o stalls or the sequencer is busy;
// pipeline depth is set by the two-bits-per-stage square root of the speed and
// acceleration magnitudes. After reset and after each host_heading write the
// sine/cosine sequencer runs (load, 30 rotations, publish); in_i.ready is low.
// Each stage holds its beat while the stage after it is full and stalled.
module world_to_vehicle_frame_top #(
  parameter int COORD_WIDTH     = wtv_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = wtv_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int ADDR_W          = (COORD_WIDTH > 32) ? 6 : 5,
  parameter int DATA_W          = (COORD_WIDTH > 32) ? 64 : 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wtv_in_if.sink            in_i,
  wtv_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = ANGLE_FRAC_BITS;
  localparam int AW  = F + 3;
  localparam int PW  = W + 33;
  localparam int RTW = W + 6;
  localparam int RW  = W + 3;
  localparam int SQ  = (W + 1) / 2;
  localparam int SQ0 = 6;
  localparam int NS  = 7 + SQ;
  localparam int XW  = wtv_pkg::CORDIC_XW;
  localparam int ZW  = wtv_pkg::CORDIC_ZW;
  localparam logic [63:0] PI_A64 =
      (64'(wtv_pkg::PI_Q30) + (64'd1 << (29 - F))) >> (30 - F);
  localparam logic signed [AW:0] PI_A   = (AW+1)'(PI_A64);
  localparam logic signed [AW:0] TWO_PI = (AW+1)'(2 * PI_A64);
  localparam logic [W-2:0] HMAX = '1;

  typedef struct packed {
    logic [5:0][W:0]      d;
    logic [AW-1:0]        crs;
    logic [AW-1:0]        hdg;
    logic [W-1:0]         curv;
    logic [11:0][PW-1:0]  prod;
    logic [11:0]          neg;
    logic [5:0][RTW-1:0]  rot;
    logic [5:0][W-1:0]    sat;
    logic [1:0]           ovf;
    logic [3:0][W-2:0]    am;
    logic [3:0][2*W-3:0]  sq;
    logic [1:0][2*W-1:0]  n;
    logic [1:0][RW-1:0]   rem;
    logic [1:0][W-1:0]    root;
    logic [1:0][W-2:0]    mag;
  } pl_t;

  // ---------------------------------------------------------------- config
  logic [5:0][W-1:0] hv_q;
  logic [AW-1:0]     hcrs_q;
  logic [AW-1:0]     hhdg_q;
  logic [2:0]        cfg_idx;
  logic              cfg_wr;

  assign cfg_idx = paddr[ADDR_W-1 -: wtv_pkg::REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the ego pose registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q   <= '0;
      hcrs_q <= '0;
      hhdg_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wtv_pkg::REG_HOST_POS_X:   hv_q[0] <= pwdata[W-1:0];
        wtv_pkg::REG_HOST_POS_Y:   hv_q[1] <= pwdata[W-1:0];
        wtv_pkg::REG_HOST_VEL_X:   hv_q[2] <= pwdata[W-1:0];
        wtv_pkg::REG_HOST_VEL_Y:   hv_q[3] <= pwdata[W-1:0];
        wtv_pkg::REG_HOST_ACC_X:   hv_q[4] <= pwdata[W-1:0];
        wtv_pkg::REG_HOST_ACC_Y:   hv_q[5] <= pwdata[W-1:0];
        wtv_pkg::REG_HOST_COURSE:  hcrs_q  <= pwdata[AW-1:0];
        wtv_pkg::REG_HOST_HEADING: hhdg_q  <= pwdata[AW-1:0];
      endcase
    end
  end

  // Read back the selected register
  always_comb begin
    unique case (cfg_idx)
      wtv_pkg::REG_HOST_POS_X:   prdata = DATA_W'(hv_q[0]);
      wtv_pkg::REG_HOST_POS_Y:   prdata = DATA_W'(hv_q[1]);
      wtv_pkg::REG_HOST_VEL_X:   prdata = DATA_W'(hv_q[2]);
      wtv_pkg::REG_HOST_VEL_Y:   prdata = DATA_W'(hv_q[3]);
      wtv_pkg::REG_HOST_ACC_X:   prdata = DATA_W'(hv_q[4]);
      wtv_pkg::REG_HOST_ACC_Y:   prdata = DATA_W'(hv_q[5]);
      wtv_pkg::REG_HOST_COURSE:  prdata = DATA_W'(hcrs_q);
      wtv_pkg::REG_HOST_HEADING: prdata = DATA_W'(hhdg_q);
    endcase
  end

  // ------------------------------------------------------- sine / cosine
  wtv_pkg::cs_state_e cs_q, cs_d;
  logic signed [XW-1:0] x_q, y_q;
  logic signed [ZW-1:0] z_q;
  logic [4:0]           it_q;
  logic                 flip_q;
  logic [31:0]          cabs_q, sabs_q;
  logic                 cneg_q, sneg_q;
  logic                 busy;
  logic                 hdg_wr;
  logic signed [ZW-1:0] z0;

  assign hdg_wr = cfg_wr && (cfg_idx == wtv_pkg::REG_HOST_HEADING);
  assign z0     = {hhdg_q[AW-1], hhdg_q, {(30 - F){1'b0}}};

  // Next state
  always_comb begin
    cs_d = cs_q;
    unique case (cs_q)
      wtv_pkg::CS_IDLE: cs_d = wtv_pkg::CS_IDLE;
      wtv_pkg::CS_LOAD: cs_d = wtv_pkg::CS_RUN;
      wtv_pkg::CS_RUN:  if (it_q == 5'(wtv_pkg::CORDIC_ITERS - 1)) cs_d = wtv_pkg::CS_DONE;
      wtv_pkg::CS_DONE: cs_d = wtv_pkg::CS_IDLE;
    endcase
    if (hdg_wr) cs_d = wtv_pkg::CS_LOAD;
  end

  // Outputs: hold off input while the rotator runs
  always_comb begin
    busy = (cs_q != wtv_pkg::CS_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cs_q <= wtv_pkg::CS_LOAD;
    else         cs_q <= cs_d;
  end

  // Fold the heading, iterate, then publish cosine and sine magnitudes and signs
  always_ff @(posedge clk_i) begin
    unique case (cs_q)
      wtv_pkg::CS_LOAD: begin
        x_q  <= wtv_pkg::CORDIC_K;
        y_q  <= '0;
        it_q <= '0;
        if (z0 > wtv_pkg::HALF_PI_Q30) begin
          z_q <= z0 - wtv_pkg::PI_Q30;  flip_q <= 1'b1;
        end else if (z0 < -wtv_pkg::HALF_PI_Q30) begin
          z_q <= z0 + wtv_pkg::PI_Q30;  flip_q <= 1'b1;
        end else begin
          z_q <= z0;                    flip_q <= 1'b0;
        end
      end
      wtv_pkg::CS_RUN: begin
        it_q <= it_q + 5'd1;
        if (z_q >= 0) begin
          x_q <= x_q - (y_q >>> it_q);
          y_q <= y_q + (x_q >>> it_q);
          z_q <= z_q - $signed({2'b00, wtv_pkg::ATAN_Q30[it_q]});
        end else begin
          x_q <= x_q + (y_q >>> it_q);
          y_q <= y_q - (x_q >>> it_q);
          z_q <= z_q + $signed({2'b00, wtv_pkg::ATAN_Q30[it_q]});
        end
      end
      wtv_pkg::CS_DONE: begin
        cneg_q <= (x_q < 0) ^ flip_q;
        sneg_q <= (y_q < 0) ^ flip_q;
        cabs_q <= (x_q < 0) ? 32'(-x_q) : 32'(x_q);
        sabs_q <= (y_q < 0) ? 32'(-y_q) : 32'(y_q);
      end
      wtv_pkg::CS_IDLE: ;
    endcase
  end

  // -------------------------------------------------------------- pipeline
  pl_t         p_q [NS];
  pl_t         nxt [NS];
  logic [NS-1:0] v_q;
  logic [NS:0]   en;
  logic          in_acc;

  always_comb begin
    en[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign in_i.ready = en[0] && !busy;
  assign in_acc     = in_i.valid && in_i.ready;

  function automatic logic [AW-1:0] wrap_ang(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic signed [AW:0] dd;
    dd = $signed({a[AW-1], a}) - $signed({b[AW-1], b});
    if (dd <= -PI_A)    dd = dd + TWO_PI;
    else if (dd > PI_A) dd = dd - TWO_PI;
    return dd[AW-1:0];
  endfunction

  // Stage 0: differences, angle wrap, curvature magnitude
  always_comb begin
    logic [5:0][W-1:0] pin;
    pin = {in_i.pt_acc_y, in_i.pt_acc_x, in_i.pt_vel_y, in_i.pt_vel_x,
           in_i.pt_pos_y, in_i.pt_pos_x};
    nxt[0] = '0;
    for (int k = 0; k < 6; k++)
      nxt[0].d[k] = $signed({pin[k][W-1], pin[k]}) - $signed({hv_q[k][W-1], hv_q[k]});
    nxt[0].crs = wrap_ang(in_i.pt_course, hcrs_q);
    nxt[0].hdg = wrap_ang(in_i.pt_heading, hhdg_q);
    if (in_i.pt_curvature == {1'b1, {(W-1){1'b0}}})
      nxt[0].curv = {1'b0, HMAX};
    else if (in_i.pt_curvature[W-1])
      nxt[0].curv = -in_i.pt_curvature;
    else
      nxt[0].curv = in_i.pt_curvature;
  end

  // Stage 1: twelve magnitude products against cosine and sine
  always_comb begin
    logic [W:0] da;
    logic       dn;
    nxt[1] = p_q[0];
    for (int k = 0; k < 6; k++) begin
      dn = p_q[0].d[k][W];
      da = dn ? -p_q[0].d[k] : p_q[0].d[k];
      if (k % 2 == 0) begin
        nxt[1].prod[2*k+0] = PW'(da) * PW'(cabs_q);
        nxt[1].neg[2*k+0]  = dn ^ cneg_q;
        nxt[1].prod[2*k+3] = PW'(da) * PW'(sabs_q);
        nxt[1].neg[2*k+3]  = dn ^ sneg_q;
      end else begin
        nxt[1].prod[2*k-1] = PW'(da) * PW'(sabs_q);
        nxt[1].neg[2*k-1]  = dn ^ sneg_q;
        nxt[1].prod[2*k]   = PW'(da) * PW'(cabs_q);
        nxt[1].neg[2*k]    = dn ^ cneg_q;
      end
    end
  end

  // Stage 2: round half away from zero and combine into rotated components
  always_comb begin
    logic [PW:0]             rs;
    logic signed [RTW-1:0]   t [4];
    nxt[2] = p_q[1];
    for (int g = 0; g < 3; g++) begin
      for (int m = 0; m < 4; m++) begin
        rs   = (PW+1)'(p_q[1].prod[4*g+m]) + ((PW+1)'(1) << 29);
        t[m] = p_q[1].neg[4*g+m] ? -$signed(RTW'(rs[PW:30])) : $signed(RTW'(rs[PW:30]));
      end
      nxt[2].rot[2*g]   = t[0] + t[1];
      nxt[2].rot[2*g+1] = t[2] - t[3];
    end
  end

  // Stage 3: saturate, curvature sign, magnitude operands
  always_comb begin
    logic signed [RTW-1:0] r;
    logic [RTW-1:0]        ra;
    nxt[3] = p_q[2];
    nxt[3].ovf = '0;
    for (int k = 0; k < 6; k++) begin
      r = $signed(p_q[2].rot[k]);
      if (r > $signed(RTW'({1'b0, HMAX})))
        nxt[3].sat[k] = {1'b0, HMAX};
      else if (r < -$signed(RTW'({1'b0, HMAX})) - 1)
        nxt[3].sat[k] = {1'b1, {(W-1){1'b0}}};
      else
        nxt[3].sat[k] = r[W-1:0];
      if (k >= 2) begin
        ra = r[RTW-1] ? -r : r;
        nxt[3].am[k-2] = ra[W-2:0];
        if (ra[RTW-1:W-1] != '0) nxt[3].ovf[(k-2)/2] = 1'b1;
      end
    end
    if ($signed(p_q[2].rot[5]) > 0) nxt[3].curv = -p_q[2].curv;
  end

  // Stage 4: squares
  always_comb begin
    nxt[4] = p_q[3];
    for (int k = 0; k < 4; k++)
      nxt[4].sq[k] = (2*W-2)'(p_q[3].am[k]) * (2*W-2)'(p_q[3].am[k]);
  end

  // Stage 5: sum of squares, start the root
  always_comb begin
    nxt[5] = p_q[4];
    for (int l = 0; l < 2; l++) begin
      nxt[5].n[l]    = (2*W)'(p_q[4].sq[2*l]) + (2*W)'(p_q[4].sq[2*l+1]);
      nxt[5].rem[l]  = '0;
      nxt[5].root[l] = '0;
    end
  end

  // Square root stages: two result bits per stage
  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    always_comb begin
      logic [RW-1:0]    rem, rt, tr;
      logic [W-1:0]     root;
      logic [2*W-1:0]   n;
      nxt[SQ0+g] = p_q[SQ0+g-1];
      for (int l = 0; l < 2; l++) begin
        rem  = p_q[SQ0+g-1].rem[l];
        root = p_q[SQ0+g-1].root[l];
        n    = p_q[SQ0+g-1].n[l];
        for (int s = 0; s < 2; s++) begin
          if (2*g + s < W) begin
            rt = {rem[RW-3:0], n[2*W-1 -: 2]};
            n  = n << 2;
            tr = {1'b0, root, 2'b01};
            if (rt >= tr) begin
              rem  = rt - tr;
              root = {root[W-2:0], 1'b1};
            end else begin
              rem  = rt;
              root = {root[W-2:0], 1'b0};
            end
          end
        end
        nxt[SQ0+g].rem[l]  = rem;
        nxt[SQ0+g].root[l] = root;
        nxt[SQ0+g].n[l]    = n;
      end
    end
  end

  // Last stage: saturate the magnitudes
  always_comb begin
    nxt[NS-1] = p_q[NS-2];
    for (int l = 0; l < 2; l++) begin
      if (p_q[NS-2].ovf[l] || p_q[NS-2].root[l][W-1]) nxt[NS-1].mag[l] = HMAX;
      else nxt[NS-1].mag[l] = p_q[NS-2].root[l][W-2:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++)
        if (en[k]) v_q[k] <= (k == 0) ? in_acc : v_q[(k == 0) ? 0 : k - 1];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++)
      if (en[k]) p_q[k] <= nxt[k];
  end

  // Drive the result beat
  assign out_o.valid         = v_q[NS-1];
  assign out_o.rel_pos_x     = p_q[NS-1].sat[0];
  assign out_o.rel_pos_y     = p_q[NS-1].sat[1];
  assign out_o.rel_course    = p_q[NS-1].crs;
  assign out_o.rel_heading   = p_q[NS-1].hdg;
  assign out_o.rel_vel_x     = p_q[NS-1].sat[2];
  assign out_o.rel_vel_y     = p_q[NS-1].sat[3];
  assign out_o.rel_speed     = p_q[NS-1].mag[0];
  assign out_o.rel_acc_x     = p_q[NS-1].sat[4];
  assign out_o.rel_acc_y     = p_q[NS-1].sat[5];
  assign out_o.rel_acc_mag   = p_q[NS-1].mag[1];
  assign out_o.rel_curvature = p_q[NS-1].curv;

endmodule

// File: tb/sv/world_to_vehicle_frame_top_test.sv
`timescale 1ns / 1ps

module world_to_vehicle_frame_top_test;

  localparam int  W          = wtv_pkg::COORD_WIDTH_DEF;
  localparam int  AW         = wtv_pkg::ANGLE_FRAC_BITS_DEF + 3;
  localparam int  PI_ANG     = 25736;
  localparam int  LATENCY    = 7 + (W + 1) / 2;
  localparam int  IDLE_LIMIT = 4000;
  localparam int  RAND_ITEMS = 140;
  localparam int  NUM_PHASES = 5;

  typedef struct {
    logic [W-1:0]  pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
    logic [AW-1:0] course, heading;
    logic [W-1:0]  curvature;
  } object_t;

  typedef struct {
    logic [W-1:0]  pos_x, pos_y;
    logic [AW-1:0] course, heading;
    logic [W-1:0]  vel_x, vel_y;
    logic [W-2:0]  speed;
    logic [W-1:0]  acc_x, acc_y;
    logic [W-2:0]  acc_mag;
    logic [W-1:0]  curvature;
  } ego_view_t;

  typedef struct {
    object_t   obj;
    bit        known;
    ego_view_t view;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  wtv_in_if  in_bus ();
  wtv_out_if out_bus ();

  world_to_vehicle_frame_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Ego pose copy and pending views
  logic [W-1:0] host_reg [wtv_pkg::NUM_REGS];
  ego_view_t    pending_views [$];
  stim_row_t    directed_rows [$];
  int           fail_count;
  int           idle_cycles;
  int           stall_left;
  bit           burst_mode;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sext(logic [63:0] v, int w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    v = v & m;
    if (v[w-1]) return longint'(v) - (longint'(1) << w);
    return longint'(v);
  endfunction

  function automatic longint sat_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) << (W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // round(a*b / 2^30), half away from zero
  function automatic longint round_mul(longint a, longint b);
    logic [127:0] prod;
    longint ua, ub, r;
    bit neg;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = prod + (128'd1 << 29);
    r    = longint'(prod >> 30);
    return neg ? -r : r;
  endfunction

  function automatic void rotator(input longint ang, output longint c, output longint s);
    longint z, x, y, sx, sy;
    bit flip;
    z    = ang * (longint'(1) << (30 - wtv_pkg::ANGLE_FRAC_BITS_DEF));
    x    = longint'(wtv_pkg::CORDIC_K);
    y    = 0;
    flip = 1'b0;
    if (z > longint'(wtv_pkg::HALF_PI_Q30)) begin
      z    = z - longint'(wtv_pkg::PI_Q30);
      flip = 1'b1;
    end else if (z < -longint'(wtv_pkg::HALF_PI_Q30)) begin
      z    = z + longint'(wtv_pkg::PI_Q30);
      flip = 1'b1;
    end
    for (int i = 0; i < wtv_pkg::CORDIC_ITERS; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (z >= 0) begin
        x = x - sx;
        y = y + sy;
        z = z - longint'(wtv_pkg::ATAN_Q30[i]);
      end else begin
        x = x + sx;
        y = y - sy;
        z = z + longint'(wtv_pkg::ATAN_Q30[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint magnitude(longint x, longint y);
    logic [127:0] ax, ay, n, r, t;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    n  = ax * ax + ay * ay;
    r  = 0;
    for (int b = 52; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= n) r = t;
    end
    if (r > ((128'd1 << (W - 1)) - 1)) r = (128'd1 << (W - 1)) - 1;
    return longint'(r);
  endfunction

  function automatic longint wrap_angle(longint d);
    if (d <= -PI_ANG) return d + 2 * PI_ANG;
    if (d > PI_ANG) return d - 2 * PI_ANG;
    return d;
  endfunction

  function automatic ego_view_t predict_view(object_t o);
    ego_view_t v;
    longint c, s, curv, acc_y;
    longint diff [6];
    longint rot [6];
    logic [W-1:0] pt [6];
    pt = '{o.pos_x, o.pos_y, o.vel_x, o.vel_y, o.acc_x, o.acc_y};
    rotator(sext(host_reg[wtv_pkg::REG_HOST_HEADING], AW), c, s);
    for (int i = 0; i < 6; i++) diff[i] = sext(pt[i], W) - sext(host_reg[i], W);
    for (int i = 0; i < 6; i += 2) begin
      rot[i]     = round_mul(diff[i], c) + round_mul(diff[i+1], s);
      rot[i + 1] = round_mul(diff[i+1], c) - round_mul(diff[i], s);
    end
    v.pos_x   = W'(sat_coord(rot[0]));
    v.pos_y   = W'(sat_coord(rot[1]));
    v.course  = AW'(wrap_angle(sext(o.course, AW) -
                               sext(host_reg[wtv_pkg::REG_HOST_COURSE], AW)));
    v.heading = AW'(wrap_angle(sext(o.heading, AW) -
                               sext(host_reg[wtv_pkg::REG_HOST_HEADING], AW)));
    v.vel_x   = W'(sat_coord(rot[2]));
    v.vel_y   = W'(sat_coord(rot[3]));
    v.speed   = (W-1)'(magnitude(rot[2], rot[3]));
    v.acc_x   = W'(sat_coord(rot[4]));
    acc_y     = sat_coord(rot[5]);
    v.acc_y   = W'(acc_y);
    v.acc_mag = (W-1)'(magnitude(rot[4], rot[5]));
    curv      = sext(o.curvature, W);
    curv      = sat_coord((curv < 0) ? -curv : curv);
    v.curvature = W'((acc_y > 0) ? -curv : curv);
    return v;
  endfunction

  // ----------------------------------------------------------------- checking
  function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic check_view(ego_view_t e);
    bit ok;
    ok = 1'b1;
    ok &= field_ok("rel_pos_x", e.pos_x, out_bus.rel_pos_x);
    ok &= field_ok("rel_pos_y", e.pos_y, out_bus.rel_pos_y);
    ok &= field_ok("rel_course", e.course, out_bus.rel_course);
    ok &= field_ok("rel_heading", e.heading, out_bus.rel_heading);
    ok &= field_ok("rel_vel_x", e.vel_x, out_bus.rel_vel_x);
    ok &= field_ok("rel_vel_y", e.vel_y, out_bus.rel_vel_y);
    ok &= field_ok("rel_speed", e.speed, out_bus.rel_speed);
    ok &= field_ok("rel_acc_x", e.acc_x, out_bus.rel_acc_x);
    ok &= field_ok("rel_acc_y", e.acc_y, out_bus.rel_acc_y);
    ok &= field_ok("rel_acc_mag", e.acc_mag, out_bus.rel_acc_mag);
    ok &= field_ok("rel_curvature", e.curvature, out_bus.rel_curvature);
    if (!ok) fail_count++;
  endtask

  // Check output beats and draw the next stall
  always @(posedge clk_i) begin
    logic ready_nxt;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_views.size() == 0) begin
          $display("%0t unexpected beat, expected none actual rel_pos_x %h",
                   $time, out_bus.rel_pos_x);
          fail_count++;
        end else begin
          check_view(pending_views.pop_front());
        end
        stall_left = burst_mode ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      out_bus.ready <= ready_nxt;
    end
  end

  // Stop on a long stretch without progress
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("world_to_vehicle_frame_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic object_t make_object(logic [W-1:0] px, logic [W-1:0] py,
                                          logic [W-1:0] vx, logic [W-1:0] vy,
                                          logic [W-1:0] ax, logic [W-1:0] ay,
                                          logic [AW-1:0] crs, logic [AW-1:0] hdg,
                                          logic [W-1:0] curv);
    object_t o;
    o = '{px, py, vx, vy, ax, ay, crs, hdg, curv};
    return o;
  endfunction

  function automatic logic [W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return {1'b0, {(W-1){1'b1}}};
      2: return {1'b1, {(W-1){1'b0}}};
      3, 4: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0001_ffff;
      default: return $signed($urandom_range(0, 32'h1fff_ffff)) - 32'sh0fff_ffff;
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    if ($urandom_range(0, 7) == 0) return AW'($urandom);
    return AW'($urandom_range(0, 2 * PI_ANG - 1) - (PI_ANG - 1));
  endfunction

  function automatic object_t rand_object();
    return make_object(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_angle(), rand_angle(),
                       rand_coord());
  endfunction

  // Present one beat, hold until accepted, queue its view
  task automatic send_object(object_t o, bit known, ego_view_t view);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.pt_pos_x     <= o.pos_x;
    in_bus.pt_pos_y     <= o.pos_y;
    in_bus.pt_vel_x     <= o.vel_x;
    in_bus.pt_vel_y     <= o.vel_y;
    in_bus.pt_acc_x     <= o.acc_x;
    in_bus.pt_acc_y     <= o.acc_y;
    in_bus.pt_course    <= o.course;
    in_bus.pt_heading   <= o.heading;
    in_bus.pt_curvature <= o.curvature;
    do @(posedge clk_i); while (!in_bus.ready);
    pending_views.insert(pending_views.size(), known ? view : predict_view(o));
  endtask

  // Drop valid and let the pipeline drain
  task automatic drain();
    in_bus.valid <= 1'b0;
    wait (pending_views.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    host_reg[idx] = (idx >= wtv_pkg::REG_HOST_COURSE) ? value[AW-1:0] : value[W-1:0];
  endtask

  task automatic load_pose(int phase);
    logic [31:0] val;
    for (int r = 0; r < wtv_pkg::NUM_REGS; r++) begin
      case (phase)
        1: val = (r >= wtv_pkg::REG_HOST_COURSE) ? rand_angle() : rand_coord();
        2: val = (r >= wtv_pkg::REG_HOST_COURSE) ? PI_ANG : {1'b0, {(W-1){1'b1}}};
        3: val = (r >= wtv_pkg::REG_HOST_COURSE) ? -(PI_ANG - 1) : {1'b1, {(W-1){1'b0}}};
        4: val = (r >= wtv_pkg::REG_HOST_COURSE) ? 32'h0000_7fff : 32'h0000_0000;
        default: val = (r >= wtv_pkg::REG_HOST_COURSE) ? 32'h0000_8000 : rand_coord();
      endcase
      write_reg(r[2:0], val);
    end
  endtask

  // Directed rows: reset pose, extremes and angle wrap edges
  task automatic build_directed();
    stim_row_t row;
    ego_view_t zero_view;
    object_t   zero_obj;
    zero_view = '{default: '0};
    zero_obj  = make_object(0, 0, 0, 0, 0, 0, 0, 0, 0);
    row = '{zero_obj, 1'b1, zero_view};
    directed_rows.insert(directed_rows.size(), row);
    // Most negative curvature saturates its magnitude
    row.obj = zero_obj;
    row.obj.curvature = {1'b1, {(W-1){1'b0}}};
    row.view = zero_view;
    row.view.curvature = {1'b0, {(W-1){1'b1}}};
    directed_rows.insert(directed_rows.size(), row);
    row.obj = zero_obj;
    row.obj.course = AW'(PI_ANG);
    row.view = zero_view;
    row.view.course = AW'(PI_ANG);
    directed_rows.insert(directed_rows.size(), row);
    row.obj = zero_obj;
    row.obj.heading = AW'(-(PI_ANG - 1));
    row.view = zero_view;
    row.view.heading = AW'(-(PI_ANG - 1));
    directed_rows.insert(directed_rows.size(), row);
    row.known = 1'b0;
    for (int i = 0; i < 6; i++) begin
      row.obj = zero_obj;
      row.obj.pos_x = (i % 2) ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      row.obj.vel_y = row.obj.pos_x;
      row.obj.acc_x = (i >= 2) ? row.obj.pos_x : '0;
      row.obj.acc_y = (i >= 4) ? ~row.obj.pos_x : row.obj.pos_x;
      row.obj.curvature = 32'h0001_0000;
      directed_rows.insert(directed_rows.size(), row);
    end
    row.obj = make_object('1, '1, '1, '1, '1, '1, '1, '1, '1);
    directed_rows.insert(directed_rows.size(), row);
    row.obj = make_object({1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}},
                          {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}},
                          {1'b0, {(W-1){1'b1}}}, {1'b0, {(W-1){1'b1}}},
                          16'h7fff, 16'h8000, {1'b0, {(W-1){1'b1}}});
    directed_rows.insert(directed_rows.size(), row);
    row.obj = make_object({1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}},
                          {1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}},
                          {1'b1, {(W-1){1'b0}}}, {1'b1, {(W-1){1'b0}}},
                          16'h8000, 16'h7fff, {1'b1, {(W-1){1'b0}}});
    directed_rows.insert(directed_rows.size(), row);
    row.obj = make_object(32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000,
                          32'h0000_8000, 32'hffff_8000, AW'(-PI_ANG + 1), AW'(PI_ANG),
                          32'hffff_0000);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  initial begin
    ego_view_t none;
    none          = '{default: '0};
    fail_count    = 0;
    idle_cycles   = 0;
    stall_left    = 0;
    burst_mode    = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_bus.valid  = 1'b0;
    in_bus.pt_pos_x = '0;
    in_bus.pt_pos_y = '0;
    in_bus.pt_vel_x = '0;
    in_bus.pt_vel_y = '0;
    in_bus.pt_acc_x = '0;
    in_bus.pt_acc_y = '0;
    in_bus.pt_course = '0;
    in_bus.pt_heading = '0;
    in_bus.pt_curvature = '0;
    out_bus.ready = 1'b0;
    for (int r = 0; r < wtv_pkg::NUM_REGS; r++) host_reg[r] = '0;
    build_directed();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk, then random objects, at the reset pose
    foreach (directed_rows[i])
      send_object(directed_rows[i].obj, directed_rows[i].known, directed_rows[i].view);
    for (int k = 0; k < RAND_ITEMS / 2; k++) send_object(rand_object(), 1'b0, none);
    drain();

    // Random phases across several poses
    for (int p = 1; p <= NUM_PHASES; p++) begin
      load_pose(p);
      burst_mode = (p == 3);
      for (int k = 0; k < RAND_ITEMS; k++) begin
        if (p == 2 && k == RAND_ITEMS / 2) begin
          in_bus.valid <= 1'b0;
          wait (pending_views.size() == 0);
          @(posedge clk_i);
        end
        send_object(rand_object(), 1'b0, none);
      end
      burst_mode = 1'b0;
      drain();
    end

    if (fail_count == 0 && pending_views.size() == 0)
      $display("world_to_vehicle_frame_top: match");
    else
      $display("world_to_vehicle_frame_top: mismatch");
    $finish;
  end

endmodule

// File: files.f
hdl/wtv_pkg.sv
hdl/wtv_in_if.sv
hdl/wtv_out_if.sv
hdl/world_to_vehicle_frame_top.sv
tb/sv/world_to_vehicle_frame_top_test.sv
